// ===== rtl/knn_pkg.sv =====
// Package for the nearest-neighbour rating predictor: widths, opcodes and
// the command/status structures shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package knn_pkg;

    // Table sizes.
    localparam int USER_W     = 8;
    localparam int NUM_USERS  = 1 << USER_W;
    localparam int ITEM_W     = 10;
    localparam int NUM_ITEMS  = 1 << ITEM_W;
    localparam int SIM_AW     = 2 * USER_W;
    localparam int RAT_AW     = USER_W + ITEM_W;
    localparam int CLR_W      = RAT_AW;

    // Field and arithmetic widths.
    localparam int OP_W       = 3;
    localparam int SIM_W      = 16;
    localparam int RAT_W      = 3;
    localparam int FRAC_W     = 8;
    localparam int SUM_W      = 13;
    localparam int CNT_W      = 11;
    localparam int MEAN_W     = 11;
    localparam int DIFF_W     = RAT_W + FRAC_W + 1;
    localparam int PROD_W     = SIM_W + DIFF_W;
    localparam int ABS_W      = SIM_W + 1;
    localparam int NUM_W      = PROD_W + USER_W;
    localparam int DEN_W      = ABS_W + USER_W - 1;
    localparam int QUO_W      = 11;
    localparam int RES_W      = QUO_W + 2;
    localparam int PRED_W     = 11;
    localparam int CFG_AW     = 1;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 16;

    localparam logic [USER_W-1:0] USER_LAST = USER_W'(NUM_USERS - 1);
    localparam logic [CLR_W-1:0]  CLR_LAST  = {CLR_W{1'b1}};

    // Opcodes.
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_WR_SIM = 3'd0;
    localparam t_op OP_WR_THR = 3'd1;
    localparam t_op OP_WR_RAT = 3'd2;
    localparam t_op OP_MEANS  = 3'd3;
    localparam t_op OP_PRED   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_MIN_RATING = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_MAX_RATING = 1'b1;

    // Kind of result loaded into the output register.
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_EMPTY,
        RES_PRED
    } t_res_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              clr_we;
        logic [CLR_W-1:0]  clr_addr;
        logic              wr_sim;
        logic              wr_thr;
        logic              upd_rat;
        logic              use_walk;
        logic [USER_W-1:0] walk_u;
        logic              walk_issue;
        logic              acc_clr;
        logic              tgt_cap;
        logic              div_start;
        logic              div_means;
        logic              mean_we;
        logic              out_load;
        t_res_kind         res_kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic cnt_zero;
        logic pipe_busy;
        logic div_busy;
    } t_stat;

endpackage

// ===== rtl/knn_div.sv =====
// Restoring divider producing an 11-bit quotient, one bit per cycle.
// Shared by the mean computation and the prediction. Depends on knn_pkg.
`timescale 1ns / 1ps

module knn_div
    import knn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [QUO_W-1:0] o_quotient
);

    localparam int QCNT_W = $clog2(QUO_W);

    logic              r_busy;
    logic [QCNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dsh;
    logic [QUO_W-1:0]  r_quo;
    logic              w_fit;

    assign w_fit = (r_rem >= r_dsh);

    // Control: the quotient must fit in QUO_W bits, which holds for both uses.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= QCNT_W'(QUO_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // One trial subtraction per cycle, highest quotient bit first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsh <= NUM_W'(i_divisor) << (QUO_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[QUO_W-2:0], w_fit};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/knn_dpath.sv =====
// Datapath of the predictor: the tables, the neighbour walk pipeline, the
// accumulators, the shared divider and the output register.
// Depends on knn_pkg and knn_div.
`timescale 1ns / 1ps

module knn_dpath
    import knn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [IN_W-1:0]   i_in_data,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [RAT_W-1:0]  i_cfg_wdata,
    output logic [OUT_W-1:0]  o_out_data
);

    // Latched transaction fields.
    t_op                r_op;
    logic [USER_W-1:0]  r_ua;
    logic [USER_W-1:0]  r_ub;
    logic [ITEM_W-1:0]  r_item;
    logic [SIM_W-1:0]   r_sv;
    logic [RAT_W-1:0]   r_rat;

    // Configuration.
    logic [RAT_W-1:0]   r_min;
    logic [RAT_W-1:0]   r_max;

    // Memories and their registered read data.
    logic [SIM_W-1:0]   mem_sim  [0:(1 << SIM_AW)-1];
    logic [RAT_W-1:0]   mem_rat  [0:(1 << RAT_AW)-1];
    logic [SIM_W-1:0]   mem_thr  [0:NUM_USERS-1];
    logic [SUM_W-1:0]   mem_sum  [0:NUM_USERS-1];
    logic [CNT_W-1:0]   mem_cnt  [0:NUM_USERS-1];
    logic [MEAN_W-1:0]  mem_mean [0:NUM_USERS-1];
    logic [SIM_W-1:0]   r_sim_q;
    logic [RAT_W-1:0]   r_rat_q;
    logic [SIM_W-1:0]   r_thr_q;
    logic [SUM_W-1:0]   r_sum_q;
    logic [CNT_W-1:0]   r_cnt_q;
    logic [MEAN_W-1:0]  r_mean_q;
    logic [MEAN_W-1:0]  r_mean_tgt;

    // Walk pipeline and accumulators.
    logic               r_v1;
    logic               r_v2;
    logic [PROD_W-1:0]  r_prod;
    logic [ABS_W-1:0]   r_abs;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;

    // Output register.
    logic [PRED_W-1:0]  r_out_pred;
    logic               r_out_status;

    // Memory port selection.
    logic               w_sim_we;
    logic [SIM_AW-1:0]  w_sim_waddr;
    logic [SIM_W-1:0]   w_sim_wdata;
    logic               w_rat_we;
    logic [RAT_AW-1:0]  w_rat_waddr;
    logic [RAT_W-1:0]   w_rat_wdata;
    logic [RAT_AW-1:0]  w_rat_raddr;
    logic               w_usr_we_thr;
    logic               w_usr_we_stat;
    logic               w_usr_we_mean;
    logic [USER_W-1:0]  w_usr_waddr;
    logic [SIM_W-1:0]   w_thr_wdata;
    logic [SUM_W-1:0]   w_sum_wdata;
    logic [CNT_W-1:0]   w_cnt_wdata;
    logic [MEAN_W-1:0]  w_mean_wdata;
    logic [USER_W-1:0]  w_usr_raddr;
    logic [USER_W-1:0]  w_mean_waddr;

    // Arithmetic.
    logic               w_old_nz;
    logic               w_new_nz;
    logic signed [SIM_W-1:0]  w_s;
    logic signed [SIM_W-1:0]  w_thr;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ABS_W-1:0]  w_s17;
    logic [ABS_W-1:0]   w_abs;
    logic               w_incl;
    logic [NUM_W-1:0]   w_num_mag;
    logic [NUM_W-1:0]   w_dividend;
    logic [DEN_W-1:0]   w_divisor;
    logic               w_div_busy;
    logic [QUO_W-1:0]   w_quo;
    logic signed [RES_W-1:0] w_q;
    logic signed [RES_W-1:0] w_ret;
    logic signed [RES_W-1:0] w_lo;
    logic signed [RES_W-1:0] w_hi;
    logic signed [RES_W-1:0] w_clamp;

    // Latch the fields of an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in_data[2:0];
            r_ua   <= i_in_data[10:3];
            r_ub   <= i_in_data[18:11];
            r_item <= i_in_data[28:19];
            r_sv   <= i_in_data[44:29];
            r_rat  <= i_in_data[47:45];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= RAT_W'(1);
            r_max <= RAT_W'(5);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_RATING: r_min <= i_cfg_wdata;
                CFG_MAX_RATING: r_max <= i_cfg_wdata;
                default:        r_min <= r_min;
            endcase
        end
    end

    // Rating write: the old rating leaves the sum and count, the new one enters.
    assign w_old_nz    = (r_rat_q != '0);
    assign w_new_nz    = (r_rat != '0);
    assign w_sum_wdata = i_cmd.clr_we ? '0 :
                         r_sum_q - SUM_W'(r_rat_q) + SUM_W'(r_rat);
    assign w_cnt_wdata = i_cmd.clr_we ? '0 :
                         r_cnt_q - CNT_W'(w_old_nz) + CNT_W'(w_new_nz);

    // Write ports: the clearing sweep after reset has priority.
    assign w_sim_we      = i_cmd.clr_we || i_cmd.wr_sim;
    assign w_sim_waddr   = i_cmd.clr_we ? i_cmd.clr_addr[SIM_AW-1:0] : {r_ua, r_ub};
    assign w_sim_wdata   = i_cmd.clr_we ? '0 : r_sv;
    assign w_rat_we      = i_cmd.clr_we || i_cmd.upd_rat;
    assign w_rat_waddr   = i_cmd.clr_we ? i_cmd.clr_addr : {r_ua, r_item};
    assign w_rat_wdata   = i_cmd.clr_we ? '0 : r_rat;
    assign w_usr_we_thr  = i_cmd.clr_we || i_cmd.wr_thr;
    assign w_usr_we_stat = i_cmd.clr_we || i_cmd.upd_rat;
    assign w_usr_we_mean = i_cmd.clr_we || i_cmd.mean_we;
    assign w_usr_waddr   = i_cmd.clr_we ? i_cmd.clr_addr[USER_W-1:0] : r_ua;
    assign w_mean_waddr  = i_cmd.clr_we ? i_cmd.clr_addr[USER_W-1:0] : i_cmd.walk_u;
    assign w_thr_wdata   = i_cmd.clr_we ? '0 : r_sv;
    assign w_mean_wdata  = (i_cmd.clr_we || r_cnt_q == '0) ? '0 : w_quo;

    // Read addresses: the walked user or the transaction's user.
    assign w_usr_raddr = i_cmd.use_walk ? i_cmd.walk_u : r_ua;
    assign w_rat_raddr = i_cmd.use_walk ? {i_cmd.walk_u, r_item} : {r_ua, r_item};

    // Memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (w_sim_we) begin
            mem_sim[w_sim_waddr] <= w_sim_wdata;
        end
        r_sim_q <= mem_sim[{r_ua, i_cmd.walk_u}];
    end

    always_ff @(posedge i_clk) begin
        if (w_rat_we) begin
            mem_rat[w_rat_waddr] <= w_rat_wdata;
        end
        r_rat_q <= mem_rat[w_rat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_usr_we_thr) begin
            mem_thr[w_usr_waddr] <= w_thr_wdata;
        end
        r_thr_q <= mem_thr[r_ua];
    end

    always_ff @(posedge i_clk) begin
        if (w_usr_we_stat) begin
            mem_sum[w_usr_waddr] <= w_sum_wdata;
            mem_cnt[w_usr_waddr] <= w_cnt_wdata;
        end
        r_sum_q <= mem_sum[w_usr_raddr];
        r_cnt_q <= mem_cnt[w_usr_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_usr_we_mean) begin
            mem_mean[w_mean_waddr] <= w_mean_wdata;
        end
        r_mean_q <= mem_mean[w_usr_raddr];
    end

    // Keep the target's mean for the final sum.
    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_cap) begin
            r_mean_tgt <= r_mean_q;
        end
    end

    // Walk stage one: neighbour test, absolute similarity and weighted deviation.
    assign w_s    = r_sim_q;
    assign w_thr  = r_thr_q;
    assign w_incl = (w_s >= w_thr);
    assign w_diff = $signed({1'b0, r_rat_q, {FRAC_W{1'b0}}}) - $signed({1'b0, r_mean_q});
    assign w_prod = w_s * w_diff;
    assign w_s17  = {w_s[SIM_W-1], w_s};
    assign w_abs  = w_s[SIM_W-1] ? ABS_W'(-w_s17) : ABS_W'(w_s17);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.walk_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= (w_incl && r_rat_q != '0) ? w_prod : '0;
        r_abs  <= w_incl ? w_abs : '0;
    end

    // Walk stage two: accumulate numerator and denominator.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_num <= '0;
            r_den <= '0;
        end else if (r_v2) begin
            r_num <= r_num + {{(NUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            r_den <= r_den + DEN_W'(r_abs);
        end
    end

    // Divider operands: sum*256/count for a mean, |num|/den for a prediction.
    assign w_num_mag  = r_num[NUM_W-1] ? -r_num : r_num;
    assign w_dividend = i_cmd.div_means ? NUM_W'({r_sum_q, {FRAC_W{1'b0}}}) : w_num_mag;
    assign w_divisor  = i_cmd.div_means ? DEN_W'(r_cnt_q) : r_den;

    knn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // Signed quotient, target mean added, then clamped to the rating range.
    always_comb begin
        if (r_den == '0) begin
            w_q = '0;
        end else if (r_num[NUM_W-1]) begin
            w_q = -$signed({2'b00, w_quo});
        end else begin
            w_q = $signed({2'b00, w_quo});
        end
    end

    assign w_ret = $signed({2'b00, r_mean_tgt}) + w_q;
    assign w_lo  = $signed({2'b00, r_min, {FRAC_W{1'b0}}});
    assign w_hi  = $signed({2'b00, r_max, {FRAC_W{1'b0}}});

    always_comb begin
        w_clamp = w_ret;
        if (w_clamp < w_lo) begin
            w_clamp = w_lo;
        end
        if (w_clamp > w_hi) begin
            w_clamp = w_hi;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.res_kind)
                RES_EMPTY: begin
                    r_out_pred   <= '0;
                    r_out_status <= 1'b1;
                end
                RES_PRED: begin
                    r_out_pred   <= w_clamp[PRED_W-1:0];
                    r_out_status <= 1'b0;
                end
                default: begin
                    r_out_pred   <= '0;
                    r_out_status <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_data = OUT_W'({r_out_status, r_out_pred});

    assign o_stat.op        = r_op;
    assign o_stat.cnt_zero  = (r_cnt_q == '0);
    assign o_stat.pipe_busy = r_v1 || r_v2;
    assign o_stat.div_busy  = w_div_busy;

endmodule

// ===== rtl/knn_ctrl.sv =====
// Controller of the predictor: clearing sweep, opcode dispatch, the user
// walks and the output handshake. Depends on knn_pkg.
`timescale 1ns / 1ps

module knn_ctrl
    import knn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RAT_UPD,
        S_MEAN_RD,
        S_MEAN_DIV,
        S_MEAN_WAIT,
        S_PRED_CHK,
        S_PRED_WALK,
        S_PRED_DRAIN,
        S_PRED_DIV,
        S_PRED_WAIT,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CLR_W-1:0]  r_clr;
    logic [USER_W-1:0] r_u;
    t_res_kind         r_res_kind;
    logic              r_out_valid;
    logic              w_out_load;

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Commands decoded from the current state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_addr = r_clr;
        o_cmd.walk_u   = r_u;
        o_cmd.res_kind = r_res_kind;
        o_cmd.out_load = w_out_load;
        case (r_state)
            S_CLEAR: o_cmd.clr_we = 1'b1;
            S_IDLE: begin
                o_cmd.load    = i_in_valid;
                o_cmd.acc_clr = 1'b1;
            end
            S_DISPATCH: begin
                o_cmd.wr_sim = (i_stat.op == OP_WR_SIM);
                o_cmd.wr_thr = (i_stat.op == OP_WR_THR);
            end
            S_RAT_UPD:   o_cmd.upd_rat = 1'b1;
            S_MEAN_RD:   o_cmd.use_walk = 1'b1;
            S_MEAN_DIV: begin
                o_cmd.use_walk  = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_means = 1'b1;
            end
            S_MEAN_WAIT: begin
                o_cmd.use_walk = 1'b1;
                o_cmd.mean_we  = !i_stat.div_busy;
            end
            S_PRED_CHK:  o_cmd.tgt_cap = 1'b1;
            S_PRED_WALK: begin
                o_cmd.use_walk   = 1'b1;
                o_cmd.walk_issue = 1'b1;
            end
            S_PRED_DIV:  o_cmd.div_start = 1'b1;
            default:     o_cmd.acc_clr = 1'b0;
        endcase
    end

    // State, walk counter, clearing address and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_u         <= '0;
            r_res_kind  <= RES_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_u        <= '0;
                    r_res_kind <= RES_ZERO;
                    case (i_stat.op)
                        OP_WR_RAT: r_state <= S_RAT_UPD;
                        OP_MEANS:  r_state <= S_MEAN_RD;
                        OP_PRED:   r_state <= S_PRED_CHK;
                        default:   r_state <= S_DONE;
                    endcase
                end
                S_RAT_UPD:  r_state <= S_DONE;
                S_MEAN_RD:  r_state <= S_MEAN_DIV;
                S_MEAN_DIV: r_state <= S_MEAN_WAIT;
                S_MEAN_WAIT: begin
                    if (!i_stat.div_busy) begin
                        if (r_u == USER_LAST) begin
                            r_state <= S_DONE;
                        end else begin
                            r_u     <= r_u + 1'b1;
                            r_state <= S_MEAN_RD;
                        end
                    end
                end
                S_PRED_CHK: begin
                    if (i_stat.cnt_zero) begin
                        r_res_kind <= RES_EMPTY;
                        r_state    <= S_DONE;
                    end else begin
                        r_state <= S_PRED_WALK;
                    end
                end
                S_PRED_WALK: begin
                    if (r_u == USER_LAST) begin
                        r_state <= S_PRED_DRAIN;
                    end else begin
                        r_u <= r_u + 1'b1;
                    end
                end
                S_PRED_DRAIN: begin
                    if (!i_stat.pipe_busy) begin
                        r_state <= S_PRED_DIV;
                    end
                end
                S_PRED_DIV: r_state <= S_PRED_WAIT;
                S_PRED_WAIT: begin
                    if (!i_stat.div_busy) begin
                        r_res_kind <= RES_PRED;
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/knn_rating_predictor.sv =====
// Top level of the user-based nearest-neighbour rating predictor.
// Depends on knn_pkg, knn_ctrl and knn_dpath.
`timescale 1ns / 1ps

// The block takes one transaction at a time and returns exactly one result
// transaction for each. After reset it sweeps its tables to zero, one rating
// entry per cycle, and takes no transaction until done. A table write passes
// through dispatch, a rating write also through an update state. A means
// transaction visits each of the 256 users with a read and a serial division.
// A prediction walks all 256 users through a pipelined multiply and accumulate,
// one user per cycle, then performs one division; a target with no ratings
// gets the empty status instead. A finished result waits in the output register.

module knn_rating_predictor
    import knn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // opcode[2:0], user_a[10:3], user_b[18:11], item[28:19],
    // sim_value[44:29], rating[47:45]
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // prediction[10:0], status[11], zero[15:12]
    output logic [OUT_W-1:0]  m_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [RAT_W-1:0]  i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    knn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    knn_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/knn_chk.sv =====
// Port-level checker for the rating predictor and its bind statement.
// Depends on knn_pkg and knn_rating_predictor.
`timescale 1ns / 1ps

module knn_chk
    import knn_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic [IN_W-1:0]   s_axis_tdata,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic              i_cfg_we,
    input logic [CFG_AW-1:0] i_cfg_addr,
    input logic [RAT_W-1:0]  i_cfg_wdata
);

    // A waiting result holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The block is clearing its tables right after reset.
    a_clear: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !s_axis_tready)
        else $error("ready during clearing sweep");

    // One transaction at a time: accepting one closes the input.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction accepted while busy");

    // A prediction never exceeds the highest rating and an error carries zero.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:0] <= 11'd1792 && m_axis_tdata[15:12] == 4'd0)
        else $error("prediction out of range");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[10:0] == 11'd0)
        else $error("error status with nonzero prediction");

endmodule

bind knn_rating_predictor knn_chk u_knn_chk (.*);
